@@ hw/rtl/iso_dt_pkg.sv @@
// shared types, codes and constants of the iso 8601 date/time parser
package iso_dt_pkg;

	// parser phases
	localparam logic [4:0] PH_IDLE     = 5'd0;
	localparam logic [4:0] PH_YEAR     = 5'd1;
	localparam logic [4:0] PH_AFT_YEAR = 5'd2;
	localparam logic [4:0] PH_MON      = 5'd3;
	localparam logic [4:0] PH_AFT_MON  = 5'd4;
	localparam logic [4:0] PH_DAY      = 5'd5;
	localparam logic [4:0] PH_AFT_DAY  = 5'd6;
	localparam logic [4:0] PH_AFT_T    = 5'd7;
	localparam logic [4:0] PH_HOUR     = 5'd8;
	localparam logic [4:0] PH_AFT_HOUR = 5'd9;
	localparam logic [4:0] PH_MIN      = 5'd10;
	localparam logic [4:0] PH_AFT_MIN  = 5'd11;
	localparam logic [4:0] PH_SEC      = 5'd12;
	localparam logic [4:0] PH_AFT_SEC  = 5'd13;
	localparam logic [4:0] PH_FRAC     = 5'd14;
	localparam logic [4:0] PH_ZH       = 5'd15;
	localparam logic [4:0] PH_AFT_ZH   = 5'd16;
	localparam logic [4:0] PH_ZM       = 5'd17;
	localparam logic [4:0] PH_DONE     = 5'd18;

	// characters of interest
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;

	// zone kinds
	localparam logic [1:0] ZONE_NONE  = 2'd0;
	localparam logic [1:0] ZONE_Z     = 2'd1;
	localparam logic [1:0] ZONE_PLUS  = 2'd2;
	localparam logic [1:0] ZONE_MINUS = 2'd3;

	// precision codes
	localparam logic [3:0] PREC_NONE   = 4'd0;
	localparam logic [3:0] PREC_YEAR   = 4'd1;
	localparam logic [3:0] PREC_MONTH  = 4'd2;
	localparam logic [3:0] PREC_DAY    = 4'd3;
	localparam logic [3:0] PREC_HOUR   = 4'd4;
	localparam logic [3:0] PREC_MINUTE = 4'd5;
	localparam logic [3:0] PREC_SECOND = 4'd6;
	localparam logic [3:0] PREC_FRAC   = 4'd7;
	localparam logic [3:0] PREC_ZHOUR  = 4'd8;
	localparam logic [3:0] PREC_ZMIN   = 4'd9;

	// weight of each year digit, most significant first
	localparam logic [15:0] YEAR_WEIGHT [4] = '{16'd1000, 16'd100, 16'd10, 16'd1};

	localparam int unsigned RES_BITS  = 95;
	localparam int unsigned TDATA_OUT = 96;

	typedef struct packed {
		logic [4:0]  phase;
		logic [1:0]  digit_pos;
		logic [15:0] year;
		logic [7:0]  month;
		logic [7:0]  day;
		logic [7:0]  hour;
		logic [7:0]  minute;
		logic [7:0]  second;
		logic [15:0] fraction;
		logic [1:0]  zone_kind;
		logic [7:0]  zone_hour;
		logic [7:0]  zone_minute;
		logic [3:0]  precision;
		logic        err;
	} parse_state_t;

	typedef struct packed {
		logic        bad_format;
		logic [3:0]  precision;
		logic [7:0]  zone_minute;
		logic [7:0]  zone_hour;
		logic [1:0]  zone_kind;
		logic [15:0] fraction;
		logic [7:0]  second;
		logic [7:0]  minute;
		logic [7:0]  hour;
		logic [7:0]  day;
		logic [7:0]  month;
		logic [15:0] year;
	} parse_result_t;

endpackage

@@ hw/rtl/iso_dt_step.sv @@
// next-state and result logic for one character of the parser
module iso_dt_step (
	input  iso_dt_pkg::parse_state_t  st,
	input  logic [7:0]                ch,
	input  logic                      first,
	input  logic                      last,
	input  logic                      time_only,
	output iso_dt_pkg::parse_state_t  nst,
	output logic                      emit,
	output iso_dt_pkg::parse_result_t res
);

	function automatic logic [7:0] add_digit(input logic [7:0] acc, input logic [7:0] d,
		input logic tens);
		logic [7:0] inc;
		inc = tens ? ({d[4:0], 3'b000} + {d[6:0], 1'b0}) : d;
		return acc + inc;
	endfunction

	iso_dt_pkg::parse_state_t s;
	iso_dt_pkg::parse_state_t n;
	logic        active;
	logic [7:0]  d8;
	logic [15:0] d16;
	logic [31:0] yprod;
	logic        tens;
	logic        ch_zone;
	logic [1:0]  zone_code;
	logic [4:0]  zone_phase;
	logic        incomplete;

	assign d8   = ch - iso_dt_pkg::CH_ZERO;
	assign d16  = {8'h00, ch} - {8'h00, iso_dt_pkg::CH_ZERO};

	assign ch_zone = (ch == iso_dt_pkg::CH_Z) || (ch == iso_dt_pkg::CH_PLUS) ||
		(ch == iso_dt_pkg::CH_MINUS);
	assign zone_code = (ch == iso_dt_pkg::CH_Z) ? iso_dt_pkg::ZONE_Z :
		(ch == iso_dt_pkg::CH_PLUS) ? iso_dt_pkg::ZONE_PLUS : iso_dt_pkg::ZONE_MINUS;
	assign zone_phase = (ch == iso_dt_pkg::CH_Z) ? iso_dt_pkg::PH_DONE : iso_dt_pkg::PH_ZH;

	always_comb begin
		active = first || (st.phase != iso_dt_pkg::PH_IDLE);
		s = st;
		if (first) begin
			s = '0;
			s.phase = time_only ? iso_dt_pkg::PH_HOUR : iso_dt_pkg::PH_YEAR;
		end
		tens  = (s.digit_pos == 2'd0);
		yprod = {16'h0000, d16} * {16'h0000, iso_dt_pkg::YEAR_WEIGHT[s.digit_pos]};
		n = s;
		unique case (s.phase) inside
			iso_dt_pkg::PH_YEAR: begin
				n.year = s.year + yprod[15:0];
				if (s.digit_pos == 2'd3) begin
					n.digit_pos = 2'd0;
					n.precision = iso_dt_pkg::PREC_YEAR;
					n.phase = iso_dt_pkg::PH_AFT_YEAR;
				end else begin
					n.digit_pos = s.digit_pos + 2'd1;
				end
			end
			iso_dt_pkg::PH_AFT_YEAR, iso_dt_pkg::PH_AFT_MON: begin
				if (ch == iso_dt_pkg::CH_T) begin
					n.phase = iso_dt_pkg::PH_AFT_T;
				end else if (ch == iso_dt_pkg::CH_MINUS) begin
					n.digit_pos = 2'd0;
					n.phase = (s.phase == iso_dt_pkg::PH_AFT_YEAR) ?
						iso_dt_pkg::PH_MON : iso_dt_pkg::PH_DAY;
				end else begin
					n.err = 1'b1;
					n.phase = iso_dt_pkg::PH_DONE;
				end
			end
			iso_dt_pkg::PH_MON: begin
				n.month = add_digit(s.month, d8, tens);
				n.digit_pos = tens ? 2'd1 : 2'd0;
				if (!tens) begin
					n.precision = iso_dt_pkg::PREC_MONTH;
					n.phase = iso_dt_pkg::PH_AFT_MON;
				end
			end
			iso_dt_pkg::PH_DAY: begin
				n.day = add_digit(s.day, d8, tens);
				n.digit_pos = tens ? 2'd1 : 2'd0;
				if (!tens) begin
					n.precision = iso_dt_pkg::PREC_DAY;
					n.phase = iso_dt_pkg::PH_AFT_DAY;
				end
			end
			iso_dt_pkg::PH_AFT_DAY: begin
				n.phase = (ch == iso_dt_pkg::CH_T) ? iso_dt_pkg::PH_AFT_T : iso_dt_pkg::PH_DONE;
			end
			iso_dt_pkg::PH_AFT_T: begin
				// first hour digit, always the tens
				n.hour = add_digit(s.hour, d8, 1'b1);
				n.digit_pos = 2'd1;
				n.phase = iso_dt_pkg::PH_HOUR;
			end
			iso_dt_pkg::PH_HOUR: begin
				n.hour = add_digit(s.hour, d8, tens);
				n.digit_pos = tens ? 2'd1 : 2'd0;
				if (!tens) begin
					n.precision = iso_dt_pkg::PREC_HOUR;
					n.phase = iso_dt_pkg::PH_AFT_HOUR;
				end
			end
			iso_dt_pkg::PH_AFT_HOUR, iso_dt_pkg::PH_AFT_MIN: begin
				if (ch_zone) begin
					n.digit_pos = 2'd0;
					n.zone_kind = zone_code;
					n.phase = zone_phase;
				end else if (ch == iso_dt_pkg::CH_COLON) begin
					n.digit_pos = 2'd0;
					n.phase = (s.phase == iso_dt_pkg::PH_AFT_HOUR) ?
						iso_dt_pkg::PH_MIN : iso_dt_pkg::PH_SEC;
				end else begin
					n.err = 1'b1;
					n.phase = iso_dt_pkg::PH_DONE;
				end
			end
			iso_dt_pkg::PH_MIN: begin
				n.minute = add_digit(s.minute, d8, tens);
				n.digit_pos = tens ? 2'd1 : 2'd0;
				if (!tens) begin
					n.precision = iso_dt_pkg::PREC_MINUTE;
					n.phase = iso_dt_pkg::PH_AFT_MIN;
				end
			end
			iso_dt_pkg::PH_SEC: begin
				n.second = add_digit(s.second, d8, tens);
				n.digit_pos = tens ? 2'd1 : 2'd0;
				if (!tens) begin
					n.precision = iso_dt_pkg::PREC_SECOND;
					n.phase = iso_dt_pkg::PH_AFT_SEC;
				end
			end
			iso_dt_pkg::PH_AFT_SEC: begin
				if (ch_zone) begin
					n.digit_pos = 2'd0;
					n.zone_kind = zone_code;
					n.phase = zone_phase;
				end else if (ch == iso_dt_pkg::CH_DOT) begin
					n.precision = iso_dt_pkg::PREC_FRAC;
					n.phase = iso_dt_pkg::PH_FRAC;
				end else begin
					n.phase = iso_dt_pkg::PH_DONE;
				end
			end
			iso_dt_pkg::PH_FRAC: begin
				if (ch_zone) begin
					n.digit_pos = 2'd0;
					n.zone_kind = zone_code;
					n.phase = zone_phase;
				end else begin
					n.fraction = {s.fraction[12:0], 3'b000} + {s.fraction[14:0], 1'b0} + d16;
				end
			end
			iso_dt_pkg::PH_ZH: begin
				n.zone_hour = add_digit(s.zone_hour, d8, tens);
				n.digit_pos = tens ? 2'd1 : 2'd0;
				if (!tens) begin
					n.precision = iso_dt_pkg::PREC_ZHOUR;
					n.phase = iso_dt_pkg::PH_AFT_ZH;
				end
			end
			iso_dt_pkg::PH_AFT_ZH: begin
				if (ch == iso_dt_pkg::CH_COLON) begin
					n.digit_pos = 2'd0;
					n.phase = iso_dt_pkg::PH_ZM;
				end else begin
					n.err = 1'b1;
					n.phase = iso_dt_pkg::PH_DONE;
				end
			end
			iso_dt_pkg::PH_ZM: begin
				n.zone_minute = add_digit(s.zone_minute, d8, tens);
				n.digit_pos = tens ? 2'd1 : 2'd0;
				if (!tens) begin
					n.precision = iso_dt_pkg::PREC_ZMIN;
					n.phase = iso_dt_pkg::PH_DONE;
				end
			end
			default: begin
			end
		endcase

		incomplete = (n.phase == iso_dt_pkg::PH_YEAR) || (n.phase == iso_dt_pkg::PH_MON) ||
			(n.phase == iso_dt_pkg::PH_DAY) || (n.phase == iso_dt_pkg::PH_HOUR) ||
			(n.phase == iso_dt_pkg::PH_MIN) || (n.phase == iso_dt_pkg::PH_SEC) ||
			(n.phase == iso_dt_pkg::PH_ZH) || (n.phase == iso_dt_pkg::PH_AFT_ZH) ||
			(n.phase == iso_dt_pkg::PH_ZM);

		res.year        = n.year;
		res.month       = n.month;
		res.day         = n.day;
		res.hour        = n.hour;
		res.minute      = n.minute;
		res.second      = n.second;
		res.fraction    = n.fraction;
		res.zone_kind   = n.zone_kind;
		res.zone_hour   = n.zone_hour;
		res.zone_minute = n.zone_minute;
		res.precision   = n.precision;
		res.bad_format  = n.err || incomplete;

		emit = active && last;
		if (emit) begin
			n.phase = iso_dt_pkg::PH_IDLE;
		end
		nst = active ? n : st;
	end

endmodule

@@ hw/rtl/iso8601_datetime_parser.sv @@
// top level of the iso 8601 date/time parser: input register, parse step, result register
//
// streaming parser for iso 8601 date, datetime and time strings, one character per
// transaction on the slave side. the first character of a string carries tuser bit 0
// (first) and tuser bit 1 selects a pure time string (sampled with first); the final
// character carries tlast. a date string opens with a four digit year, then optional
// "-MM", "-DD" and a 'T' with a time; a time is "hh", ":mm", ":ss", ".fff..." and an
// optional zone "Z", "+hh:mm" or "-hh:mm". on the final character exactly one result
// transaction leaves the master side with every field, the precision reached and a
// bad_format flag (wrong separator, or the string ended inside a group or after a sign).
// characters outside a string are dropped without a result; a new first character
// restarts parsing. digits are taken as the character code minus 48 with no check.
// throughput is one character per clock cycle while the receiver takes results; a result
// is presented once its final character has passed the input register and the parse
// step has fed the result register. the single phase register and its accumulators,
// updated once per character, set that rate. a result held by a stalled receiver
// stops the input register and then the slave side.
// there are no configuration registers.
module iso8601_datetime_parser (
	input  logic        clk,
	input  logic        arst_n,
	// slave side: characters
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] ch
	input  logic [1:0]  s_axis_tuser,   // [0] first, [1] time_only
	input  logic        s_axis_tlast,   // last character of the string
	// master side: parsed results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata    // [15:0] year, [23:16] month, [31:24] day,
	                                    // [39:32] hour, [47:40] minute, [55:48] second,
	                                    // [71:56] fraction, [73:72] zone_kind,
	                                    // [81:74] zone_hour, [89:82] zone_minute,
	                                    // [93:90] precision, [94] bad_format, [95] zero
);

	// input register stage
	logic       vld_s1;
	logic [7:0] ch_s1;
	logic       first_s1;
	logic       last_s1;
	logic       tonly_s1;

	// parser state and result register
	iso_dt_pkg::parse_state_t  st_q;
	iso_dt_pkg::parse_state_t  st_next;
	iso_dt_pkg::parse_result_t res_comb;
	iso_dt_pkg::parse_result_t res_q;
	logic                      emit;
	logic                      out_vld_q;
	logic                      advance;

	// the character in stage one is consumed whenever the result register can take a result
	assign advance       = vld_s1 && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	// payload of stage one needs no reset
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ch_s1    <= s_axis_tdata;
			first_s1 <= s_axis_tuser[0];
			tonly_s1 <= s_axis_tuser[1];
			last_s1  <= s_axis_tlast;
		end
	end

	iso_dt_step u_step (
		.st        (st_q),
		.ch        (ch_s1),
		.first     (first_s1),
		.last      (last_s1),
		.time_only (tonly_s1),
		.nst       (st_next),
		.emit      (emit),
		.res       (res_comb)
	);

	// parser state: phase idle and all accumulators zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance && emit) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res_comb;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(iso_dt_pkg::TDATA_OUT - iso_dt_pkg::RES_BITS){1'b0}}, res_q};

`ifndef SYNTH
	// precision never runs past the zone minute
	a_prec_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.precision <= iso_dt_pkg::PREC_ZMIN)
		else $error("precision out of range");

	// phase stays within the defined phases
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase <= iso_dt_pkg::PH_DONE)
		else $error("phase out of range");

	// a new result only follows a final character consumed in the cycle before
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(advance && last_s1))
		else $error("result without a final character");

	// after a result is produced the parser is idle
	a_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |=> (st_q.phase == iso_dt_pkg::PH_IDLE))
		else $error("parser not idle after result");
`endif

endmodule
